>>> rtl/abs_pkg.sv
package abs_pkg;

    localparam int MAX_PIXELS = 65536;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);

    localparam int PIX_W     = 8;
    localparam int BG_W      = 16;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 3;

    // product of a Q8.8 entry and a 9-bit factor
    localparam int PROD_W    = BG_W + CFG_W;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FG_RATE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BG_RATE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_RATIO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_RATIO = 3'd4;

    localparam logic [CFG_W-1:0] RST_LEARN_RATE  = 9'd51;
    localparam logic [CFG_W-1:0] RST_FG_RATE     = 9'd5;
    localparam logic [CFG_W-1:0] RST_BG_RATE     = 9'd26;
    localparam logic [CFG_W-1:0] RST_UPPER_RATIO = 9'd294;
    localparam logic [CFG_W-1:0] RST_LOWER_RATIO = 9'd218;

    // unity blend weight, 1.0 in units of 1/256
    localparam logic [CFG_W-1:0] RATE_ONE = 9'd256;

    typedef struct packed {
        logic [CFG_W-1:0] learn_rate;
        logic [CFG_W-1:0] fg_rate;
        logic [CFG_W-1:0] bg_rate;
        logic [CFG_W-1:0] upper_ratio;
        logic [CFG_W-1:0] lower_ratio;
    } cfg_t;

endpackage

>>> rtl/abs_ram.sv
module abs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/abs_datapath.sv
module abs_datapath (
    input  abs_pkg::cfg_t                cfg,
    input  logic [abs_pkg::BG_W-1:0]     bg,
    input  logic [abs_pkg::PIX_W-1:0]    pix,
    input  logic                         detect,
    input  logic                         model_valid,
    output logic                         fg,
    output logic [abs_pkg::BG_W-1:0]     nbg
);

    // bg' = (bg*(256-r) + (pix*256)*r) >> 8, weight saturated at 256
    function automatic logic [abs_pkg::BG_W-1:0] blend(
        input logic [abs_pkg::BG_W-1:0]  b,
        input logic [abs_pkg::PIX_W-1:0] p,
        input logic [abs_pkg::CFG_W-1:0] rate
    );
        logic [abs_pkg::CFG_W-1:0]  r;
        logic [abs_pkg::CFG_W-1:0]  inv;
        logic [abs_pkg::PROD_W-1:0] keep;
        logic [abs_pkg::PROD_W-1:0] take;
        logic [abs_pkg::PROD_W:0]   sum;
        r    = (rate > abs_pkg::RATE_ONE) ? abs_pkg::RATE_ONE : rate;
        inv  = abs_pkg::RATE_ONE - r;
        keep = abs_pkg::PROD_W'(b) * abs_pkg::PROD_W'(inv);
        take = abs_pkg::PROD_W'({p, 8'd0}) * abs_pkg::PROD_W'(r);
        sum  = {1'b0, keep} + {1'b0, take};
        return sum[abs_pkg::BG_W+7:8];
    endfunction

    logic [abs_pkg::PROD_W-1:0] p16;
    logic [abs_pkg::PROD_W-1:0] upper_lim;
    logic [abs_pkg::PROD_W-1:0] lower_lim;
    logic                       outside;
    logic [abs_pkg::CFG_W-1:0]  rate_a;
    logic [abs_pkg::BG_W-1:0]   blend_a;
    logic [abs_pkg::BG_W-1:0]   blend_b;

    assign p16       = abs_pkg::PROD_W'({pix, 16'd0});
    assign upper_lim = abs_pkg::PROD_W'(bg) * abs_pkg::PROD_W'(cfg.upper_ratio);
    assign lower_lim = abs_pkg::PROD_W'(bg) * abs_pkg::PROD_W'(cfg.lower_ratio);
    assign outside   = (p16 > upper_lim) || (p16 < lower_lim);

    // both blends run in parallel; the threshold result only selects
    assign rate_a  = detect ? cfg.fg_rate : cfg.learn_rate;
    assign blend_a = blend(bg, pix, rate_a);
    assign blend_b = blend(bg, pix, cfg.bg_rate);

    always_comb
    begin
        fg  = 1'b0;
        nbg = {pix, 8'd0};
        if (model_valid)
        begin
            if (detect)
            begin
                fg  = outside;
                nbg = outside ? blend_a : blend_b;
            end
            else
            begin
                nbg = blend_a;
            end
        end
    end

endmodule

>>> rtl/adaptive_background_subtractor.sv
// Running-average background subtractor for a stream of grey pixels in raster
// order, one background entry (Q8.8) per pixel position.
// Input channel: pixel_value, mode (0 learn, 1 detect), frame_end; a request is
// taken when in_valid is high and in_stall low. Output channel: foreground,
// background_level, last_of_frame, one request per detect pixel; learn pixels
// give none. Configuration: write cfg_data to register cfg_index while cfg_we
// is high, only while the block is idle; unknown indexes are ignored.
// Throughput: one pixel per cycle while in_stall is low. Each taken pixel
// enters the working stage; a detect result then enters the output register.
// The store is read when a pixel is taken and written when it leaves the
// working stage; a pixel hitting the entry being written gets it forwarded.
// Reset: registers return to their defaults, the pixel address goes to zero
// and the model is empty, so the first learn frame loads the store directly.
// The store itself is not cleared.
// Stall: a result waits in the output register while out_stall is high; one
// more pixel can wait in the working stage, after which in_stall rises.
module adaptive_background_subtractor (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [abs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [abs_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [abs_pkg::PIX_W-1:0]        pixel_value,
    input  logic                             mode,
    input  logic                             frame_end,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             foreground,
    output logic [abs_pkg::PIX_W-1:0]        background_level,
    output logic                             last_of_frame
);

    abs_pkg::cfg_t cfg_reg;
    abs_pkg::cfg_t cfg_next;

    logic [abs_pkg::ADDR_W-1:0] addr_reg;
    logic [abs_pkg::ADDR_W-1:0] addr_next;
    logic                       model_valid_reg;
    logic                       model_valid_next;

    // working stage
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic [abs_pkg::PIX_W-1:0]  s1_pix_reg;
    logic                       s1_detect_reg;
    logic                       s1_last_reg;
    logic                       s1_mv_reg;
    logic [abs_pkg::ADDR_W-1:0] s1_addr_reg;
    logic                       s1_hit_reg;
    logic                       s1_hit_next;
    logic [abs_pkg::BG_W-1:0]   fwd_data_reg;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       out_fg_reg;
    logic [abs_pkg::PIX_W-1:0]  out_level_reg;
    logic                       out_last_reg;

    logic                       in_accept;
    logic                       s1_adv;
    logic [abs_pkg::BG_W-1:0]   ram_rdata;
    logic [abs_pkg::BG_W-1:0]   bg_cur;
    logic                       fg_calc;
    logic [abs_pkg::BG_W-1:0]   nbg_calc;

    // a learn pixel leaves at once; a detect pixel needs room at the output
    assign s1_adv    = s1_valid_reg && (!s1_detect_reg || !out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                abs_pkg::REG_LEARN_RATE:  cfg_next.learn_rate  = cfg_data;
                abs_pkg::REG_FG_RATE:     cfg_next.fg_rate     = cfg_data;
                abs_pkg::REG_BG_RATE:     cfg_next.bg_rate     = cfg_data;
                abs_pkg::REG_UPPER_RATIO: cfg_next.upper_ratio = cfg_data;
                abs_pkg::REG_LOWER_RATIO: cfg_next.lower_ratio = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        addr_next        = addr_reg;
        model_valid_next = model_valid_reg;
        if (in_accept)
        begin
            if (frame_end)
            begin
                addr_next = '0;
                if (!mode)
                begin
                    model_valid_next = 1'b1;
                end
            end
            else if (addr_reg == abs_pkg::ADDR_W'(abs_pkg::MAX_PIXELS - 1))
            begin
                addr_next = '0;
            end
            else
            begin
                addr_next = addr_reg + 1'b1;
            end
        end
    end

    // entry read this cycle while the previous pixel writes it: forward
    assign s1_hit_next   = s1_adv && (s1_addr_reg == addr_reg);
    assign s1_valid_next = in_accept || (s1_valid_reg && !s1_adv);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv && s1_detect_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.learn_rate  <= abs_pkg::RST_LEARN_RATE;
            cfg_reg.fg_rate     <= abs_pkg::RST_FG_RATE;
            cfg_reg.bg_rate     <= abs_pkg::RST_BG_RATE;
            cfg_reg.upper_ratio <= abs_pkg::RST_UPPER_RATIO;
            cfg_reg.lower_ratio <= abs_pkg::RST_LOWER_RATIO;
            addr_reg            <= '0;
            model_valid_reg     <= 1'b0;
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg         <= cfg_next;
            addr_reg        <= addr_next;
            model_valid_reg <= model_valid_next;
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pix_reg    <= pixel_value;
            s1_detect_reg <= mode;
            s1_last_reg   <= frame_end;
            s1_mv_reg     <= model_valid_reg;
            s1_addr_reg   <= addr_reg;
            s1_hit_reg    <= s1_hit_next;
        end
        if (s1_adv)
        begin
            fwd_data_reg <= nbg_calc;
        end
        if (s1_adv && s1_detect_reg)
        begin
            out_fg_reg    <= fg_calc;
            out_level_reg <= nbg_calc[abs_pkg::BG_W-1:abs_pkg::BG_W-abs_pkg::PIX_W];
            out_last_reg  <= s1_last_reg;
        end
    end

    abs_ram #(
        .WIDTH (abs_pkg::BG_W),
        .DEPTH (abs_pkg::MAX_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_addr_reg),
        .wdata (nbg_calc),
        .re    (in_accept),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign bg_cur = s1_hit_reg ? fwd_data_reg : ram_rdata;

    abs_datapath u_datapath (
        .cfg         (cfg_reg),
        .bg          (bg_cur),
        .pix         (s1_pix_reg),
        .detect      (s1_detect_reg),
        .model_valid (s1_mv_reg),
        .fg          (fg_calc),
        .nbg         (nbg_calc)
    );

    assign out_valid        = out_valid_reg;
    assign foreground       = out_fg_reg;
    assign background_level = out_level_reg;
    assign last_of_frame    = out_last_reg;

endmodule

>>> rtl/abs_checker.sv
module abs_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          mode,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          foreground,
    input  logic [abs_pkg::PIX_W-1:0]     background_level,
    input  logic                          last_of_frame
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(foreground)
            && $stable(background_level) && $stable(last_of_frame))
        else $error("stalled result changed");

    // the input side backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // a taken detect request reaches the output via the working stage when free to move
    a_detect_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && mode) ##1 !out_stall |=> out_valid)
        else $error("detect result missing");

endmodule

bind adaptive_background_subtractor abs_checker u_abs_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .foreground       (foreground),
    .background_level (background_level),
    .last_of_frame    (last_of_frame)
);

>>> bench/adaptive_background_subtractor_tb.sv
`timescale 1ns / 100ps

module adaptive_background_subtractor_tb;

    localparam logic MODE_LEARN  = 1'b0;
    localparam logic MODE_DETECT = 1'b1;

    // first index past the register list; writes there are ignored
    localparam logic [abs_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd5;

    // longest frame sent; the fill frame writes every entry such a frame reads
    localparam int MAX_FRAME_PIXELS = 24;
    localparam int FIRST_LEARN_ROW  = 4;
    localparam int NUM_PROBES       = 19;
    localparam int NUM_SEGMENTS     = 6;
    localparam int SEGMENT_ITEMS    = 100;
    localparam int DRAIN_CYCLES     = 8;
    localparam int HOLD_OFF_CYCLES  = 40;
    localparam int QUIET_LIMIT      = 1000;

    typedef struct packed {
        logic                      fg;
        logic [abs_pkg::PIX_W-1:0] level;
        logic                      last;
    } pixel_verdict_t;

    typedef struct packed {
        logic [abs_pkg::PIX_W-1:0] pixel;
        logic                      op;
        logic                      last;
        logic                      typed_in;
        pixel_verdict_t            verdict;
    } probe_t;

    localparam pixel_verdict_t NO_VERDICT = '0;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [abs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [abs_pkg::CFG_W-1:0]     cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic [abs_pkg::PIX_W-1:0]     pixel_value;
    logic                          mode;
    logic                          frame_end;
    logic                          out_valid;
    logic                          out_stall;
    logic                          foreground;
    logic [abs_pkg::PIX_W-1:0]     background_level;
    logic                          last_of_frame;

    // shadow copy of the block's state
    bit [abs_pkg::BG_W-1:0]     bg_store [abs_pkg::MAX_PIXELS];
    logic [abs_pkg::ADDR_W-1:0] pix_addr;
    bit                         model_ready;
    abs_pkg::cfg_t              cur_cfg;

    pixel_verdict_t  predicted_verdicts [$];
    pixel_verdict_t  oldest;
    int              mismatches;
    int              send_idle_pct;
    int              recv_stall_pct;
    int              hold_off_asked;
    int              hold_off_seen;
    int              hold_off_left;
    int              quiet_cycles;

    // directed rows: no model yet, then the first learned frame and detect extremes
    probe_t probes [NUM_PROBES] = '{
        '{8'd0,   MODE_DETECT, 1'b0, 1'b1, '{1'b0, 8'd0,   1'b0}},
        '{8'd255, MODE_DETECT, 1'b0, 1'b1, '{1'b0, 8'd255, 1'b0}},
        '{8'd77,  MODE_LEARN,  1'b0, 1'b0, NO_VERDICT},
        '{8'd128, MODE_DETECT, 1'b1, 1'b1, '{1'b0, 8'd128, 1'b1}},
        '{8'd100, MODE_LEARN,  1'b0, 1'b0, NO_VERDICT},
        '{8'd200, MODE_LEARN,  1'b0, 1'b0, NO_VERDICT},
        '{8'd0,   MODE_LEARN,  1'b1, 1'b0, NO_VERDICT},
        '{8'd100, MODE_DETECT, 1'b0, 1'b1, '{1'b0, 8'd100, 1'b0}},
        '{8'd200, MODE_DETECT, 1'b0, 1'b1, '{1'b0, 8'd200, 1'b0}},
        '{8'd0,   MODE_DETECT, 1'b1, 1'b1, '{1'b0, 8'd0,   1'b1}},
        '{8'd255, MODE_DETECT, 1'b0, 1'b0, NO_VERDICT},
        '{8'd0,   MODE_DETECT, 1'b0, 1'b0, NO_VERDICT},
        '{8'd255, MODE_DETECT, 1'b1, 1'b0, NO_VERDICT},
        '{8'd255, MODE_LEARN,  1'b0, 1'b0, NO_VERDICT},
        '{8'd0,   MODE_LEARN,  1'b0, 1'b0, NO_VERDICT},
        '{8'd128, MODE_LEARN,  1'b1, 1'b0, NO_VERDICT},
        '{8'd1,   MODE_DETECT, 1'b0, 1'b0, NO_VERDICT},
        '{8'd254, MODE_DETECT, 1'b0, 1'b0, NO_VERDICT},
        '{8'd128, MODE_DETECT, 1'b1, 1'b0, NO_VERDICT}
    };

    adaptive_background_subtractor DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .pixel_value      (pixel_value),
        .mode             (mode),
        .frame_end        (frame_end),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .foreground       (foreground),
        .background_level (background_level),
        .last_of_frame    (last_of_frame)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [abs_pkg::BG_W-1:0] blend_q88(
        input int unsigned cur,
        input logic [abs_pkg::PIX_W-1:0] pix,
        input logic [abs_pkg::CFG_W-1:0] rate
    );
        int unsigned r;
        int unsigned mix;
        r = (rate > abs_pkg::RATE_ONE) ? int'(abs_pkg::RATE_ONE) : int'(rate);
        mix = (cur * (int'(abs_pkg::RATE_ONE) - r) + (int'(pix) << 8) * r) >> 8;
        return mix[abs_pkg::BG_W-1:0];
    endfunction

    function automatic void update_background(input logic [abs_pkg::PIX_W-1:0] pix,
                                              input logic op,
                                              input logic last,
                                              output bit has_verdict,
                                              output pixel_verdict_t verdict);
        int unsigned cur;
        int unsigned p16;
        logic [abs_pkg::BG_W-1:0] upd;
        bit fg;
        cur = bg_store[pix_addr];
        fg = 1'b0;
        if (!model_ready)
        begin
            upd = {pix, 8'd0};
        end
        else if (op == MODE_LEARN)
        begin
            upd = blend_q88(cur, pix, cur_cfg.learn_rate);
        end
        else
        begin
            p16 = int'(pix) << 16;
            fg = (p16 > cur * cur_cfg.upper_ratio) || (p16 < cur * cur_cfg.lower_ratio);
            upd = blend_q88(cur, pix, fg ? cur_cfg.fg_rate : cur_cfg.bg_rate);
        end
        bg_store[pix_addr] = upd;
        has_verdict = (op == MODE_DETECT);
        verdict.fg = fg;
        verdict.level = upd[abs_pkg::BG_W-1:8];
        verdict.last = last;
        if (last)
        begin
            if (op == MODE_LEARN)
                model_ready = 1'b1;
            pix_addr = '0;
        end
        else
        begin
            pix_addr = pix_addr + 1'b1;
        end
    endfunction

    // aim at the thresholds, at the current background or at 0 and 255 twice as often as at random levels
    function automatic logic [abs_pkg::PIX_W-1:0] pick_pixel();
        int unsigned cur;
        int t;
        cur = bg_store[pix_addr];
        case ($urandom_range(0, 5))
            0: t = int'((cur * cur_cfg.upper_ratio) >> 16) + int'($urandom_range(0, 2)) - 1;
            1: t = int'((cur * cur_cfg.lower_ratio) >> 16) + int'($urandom_range(0, 2)) - 1;
            2: t = int'(cur >> 8) + int'($urandom_range(0, 2)) - 1;
            3: t = $urandom_range(0, 1) ? 255 : 0;
            default: t = $urandom_range(0, 255);
        endcase
        if (t < 0)
            t = 0;
        if (t > 255)
            t = 255;
        return t[abs_pkg::PIX_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic offer_pixel(input logic [abs_pkg::PIX_W-1:0] pix, input logic op,
                               input logic last,
                               input logic typed_in, input pixel_verdict_t typed);
        bit has_verdict;
        pixel_verdict_t verdict;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_value <= pix;
        mode        <= op;
        frame_end   <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        update_background(pix, op, last, has_verdict, verdict);
        if (has_verdict)
            predicted_verdicts = {predicted_verdicts, typed_in ? typed : verdict};
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (predicted_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [abs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [abs_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic load_settings(input abs_pkg::cfg_t plan);
        put_reg(abs_pkg::REG_LEARN_RATE, plan.learn_rate);
        put_reg(abs_pkg::REG_FG_RATE, plan.fg_rate);
        put_reg(abs_pkg::REG_BG_RATE, plan.bg_rate);
        put_reg(abs_pkg::REG_UPPER_RATIO, plan.upper_ratio);
        put_reg(abs_pkg::REG_LOWER_RATIO, plan.lower_ratio);
        // unknown index: must not disturb any register
        put_reg(REG_FIRST_UNUSED + abs_pkg::CFG_IDX_W'($urandom_range(0, 2)),
                abs_pkg::CFG_W'($urandom));
        cfg_we <= 1'b0;
        cur_cfg = plan;
    endtask

    // result side: check, then decide the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_verdicts.size() == 0)
                begin
                    report_mismatch("result arrived with none expected");
                end
                else
                begin
                    oldest = predicted_verdicts.pop_front();
                    if (foreground !== oldest.fg)
                        report_mismatch($sformatf("foreground %b, expected %b",
                                                  foreground, oldest.fg));
                    if (background_level !== oldest.level)
                        report_mismatch($sformatf("background_level %0d, expected %0d",
                                                  background_level, oldest.level));
                    if (last_of_frame !== oldest.last)
                        report_mismatch($sformatf("last_of_frame %b, expected %b",
                                                  last_of_frame, oldest.last));
                end
            end
            if (hold_off_seen != hold_off_asked)
            begin
                hold_off_seen = hold_off_asked;
                hold_off_left = HOLD_OFF_CYCLES;
            end
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        abs_pkg::cfg_t plan;
        int   sent;
        int   flen;
        int   kind;
        logic op;

        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        pixel_value <= '0;
        mode        <= MODE_LEARN;
        frame_end   <= 1'b0;
        out_stall   <= 1'b0;
        mismatches     = 0;
        quiet_cycles   = 0;
        hold_off_asked = 0;
        hold_off_seen  = 0;
        hold_off_left  = 0;
        send_idle_pct  = 35;
        recv_stall_pct = 57;
        pix_addr    = '0;
        model_ready = 1'b0;
        cur_cfg     = '{abs_pkg::RST_LEARN_RATE, abs_pkg::RST_FG_RATE, abs_pkg::RST_BG_RATE,
                        abs_pkg::RST_UPPER_RATIO, abs_pkg::RST_LOWER_RATIO};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_PROBES; i++)
        begin
            // before the first learned frame: one detect frame as long as any later frame
            if (i == FIRST_LEARN_ROW)
            begin
                for (int n = 0; n < MAX_FRAME_PIXELS; n++)
                    offer_pixel(abs_pkg::PIX_W'($urandom_range(0, 255)), MODE_DETECT,
                                n == MAX_FRAME_PIXELS - 1, 1'b0, NO_VERDICT);
            end
            offer_pixel(probes[i].pixel, probes[i].op, probes[i].last,
                        probes[i].typed_in, probes[i].verdict);
        end

        for (int seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            settle();
            send_idle_pct  = (seg < 2) ? 35 : (seg < 4) ? 57 : 0;
            recv_stall_pct = (seg < 2) ? 57 : (seg < 4) ? 35 : 0;
            case (seg)
                0: plan = '0;
                1: plan = '1;
                2: plan = '{abs_pkg::RATE_ONE, abs_pkg::RATE_ONE, abs_pkg::RATE_ONE,
                            abs_pkg::CFG_W'($urandom), abs_pkg::CFG_W'($urandom)};
                4: plan = '{abs_pkg::RST_LEARN_RATE, abs_pkg::RST_FG_RATE,
                            abs_pkg::RST_BG_RATE, abs_pkg::RST_UPPER_RATIO,
                            abs_pkg::RST_LOWER_RATIO};
                default: plan = '{abs_pkg::CFG_W'($urandom_range(0, 300)),
                                  abs_pkg::CFG_W'($urandom_range(0, 300)),
                                  abs_pkg::CFG_W'($urandom_range(0, 300)),
                                  abs_pkg::CFG_W'($urandom),
                                  abs_pkg::CFG_W'($urandom)};
            endcase
            load_settings(plan);
            if (seg == NUM_SEGMENTS - 1)
                hold_off_asked++;
            sent = 0;
            while (sent < SEGMENT_ITEMS)
            begin
                flen = $urandom_range(1, MAX_FRAME_PIXELS);
                kind = $urandom_range(0, 9);
                // keep detect pixels coming while the result side holds off
                if (seg == NUM_SEGMENTS - 1 && sent == 0)
                begin
                    kind = 3;
                    flen = MAX_FRAME_PIXELS;
                end
                for (int p = 0; p < flen; p++)
                begin
                    if (kind < 3)
                        op = MODE_LEARN;
                    else if (kind < 9)
                        op = MODE_DETECT;
                    else
                        op = $urandom_range(0, 1) ? MODE_DETECT : MODE_LEARN;
                    offer_pixel(pick_pixel(), op, p == flen - 1, 1'b0, NO_VERDICT);
                end
                sent += flen;
            end
        end

        settle();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
